### src/ecsd_pkg.sv
package ecsd_pkg;

  // escape byte and command types
  localparam logic [7:0] ESC_BYTE     = 8'hFF;
  localparam logic [7:0] TYPE_WINSIZE = 8'd1;
  localparam logic [7:0] TYPE_PING    = 8'd2;
  localparam logic [7:0] TYPE_PONG    = 8'd3;

  // escape_count codes
  localparam logic [2:0] CNT_IDLE = 3'd0;
  localparam logic [2:0] CNT_ESC  = 3'd1;
  localparam logic [2:0] CNT_PAY0 = 3'd2;
  localparam logic [2:0] CNT_LAST = 3'd5;
  localparam logic [2:0] SEQ_LEN  = 3'd6;

  // result kinds
  localparam logic [2:0] KIND_DATA    = 3'd0;
  localparam logic [2:0] KIND_WINSIZE = 3'd1;
  localparam logic [2:0] KIND_PING    = 3'd2;
  localparam logic [2:0] KIND_PONG    = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  typedef struct packed {
    logic       valid;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [31:0] cookie;
    logic [15:0] rows;
    logic [15:0] cols;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t res;
  } res_item_t;

endpackage

### src/escape_command_stream_decoder_core.sv
// escape command stream decoder
// input channel: one byte of the escaped stream per item on in_byte_i,
//   taken at a clock edge with in_valid_i high and in_stall_o low
// output channel: one result item per out_valid_o edge with out_stall_i
//   low; kind_o says data byte, window size, ping, pong or bad command,
//   and the fields that do not belong to that kind read zero
// bytes of an escape sequence that is not yet complete give no result
// a result is offered from the result register once the byte completing
//   it has passed the input register and the decode into the result
//   register
// throughput: one byte per cycle while no result waits for the output slot,
//   set by the single decode step between the input and result registers
// a stalled receiver holds the result register; bytes that give no
//   result keep flowing, and the first one that needs the output slot
//   waits in the input register, raising in_stall_o
// reset clears both valid bits and returns the sequence counter to idle
module escape_command_stream_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [31:0] cookie_o,
  output logic [15:0] rows_o,
  output logic [15:0] cols_o
);
  import ecsd_pkg::*;

  in_item_t  item;     // byte waiting in the input register
  res_item_t res_item; // decoded result and its push strobe
  result_t   res;      // result register contents
  logic      adv;      // held byte moves through the decoder this cycle
  logic      out_free; // result register can take a new item

  ecsd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .adv_i      (adv),
    .item_o     (item)
  );

  // sequence state and the per-byte decode
  ecsd_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item),
    .out_free_i (out_free),
    .adv_o      (adv),
    .res_o      (res_item)
  );

  ecsd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res_item),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign kind_o      = res.kind;
  assign data_byte_o = res.data_byte;
  assign cookie_o    = res.cookie;
  assign rows_o      = res.rows;
  assign cols_o      = res.cols;

endmodule

### src/ecsd_in_reg.sv
module ecsd_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        in_byte_i,
  input  logic              adv_i,
  output ecsd_pkg::in_item_t item_o
);
  import ecsd_pkg::*;

  logic       valid_q;
  logic [7:0] value_q;

  // hold the byte only while it cannot move into the decoder
  assign in_stall_o = valid_q && !adv_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      value_q <= in_byte_i;
    end
  end

  assign item_o.valid = valid_q;
  assign item_o.value = value_q;

endmodule

### src/ecsd_decode.sv
module ecsd_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ecsd_pkg::in_item_t  item_i,
  input  logic                out_free_i,
  output logic                adv_o,
  output ecsd_pkg::res_item_t res_o
);
  import ecsd_pkg::*;

  logic [2:0]  cnt_q, cnt_d;
  logic [1:0]  cmd_q, cmd_d;
  logic [31:0] pay_q, pay_d;
  logic [31:0] shifted;
  logic [7:0]  b;
  logic        res_valid;
  result_t     res;

  assign b       = item_i.value;
  assign shifted = {pay_q[23:0], b};

  always_comb begin
    cnt_d     = cnt_q;
    cmd_d     = cmd_q;
    pay_d     = pay_q;
    res_valid = 1'b0;
    res       = '0;
    if (cnt_q == CNT_IDLE || cnt_q >= SEQ_LEN) begin
      if (b != ESC_BYTE) begin
        cnt_d         = CNT_IDLE;
        res_valid     = 1'b1;
        res.kind      = KIND_DATA;
        res.data_byte = b;
      end else begin
        cnt_d = CNT_ESC;
      end
    end else if (cnt_q == CNT_ESC) begin
      if (b == ESC_BYTE) begin
        cnt_d         = CNT_IDLE;
        res_valid     = 1'b1;
        res.kind      = KIND_DATA;
        res.data_byte = ESC_BYTE;
      end else if (b == TYPE_WINSIZE || b == TYPE_PING || b == TYPE_PONG) begin
        cmd_d = b[1:0];
        pay_d = '0;
        cnt_d = CNT_PAY0;
      end else begin
        cnt_d     = CNT_IDLE;
        res_valid = 1'b1;
        res.kind  = KIND_ERROR;
      end
    end else begin
      pay_d = shifted;
      if (cnt_q == CNT_LAST) begin
        cnt_d     = CNT_IDLE;
        res_valid = 1'b1;
        case (cmd_q)
          TYPE_WINSIZE[1:0]: begin
            res.kind = KIND_WINSIZE;
            res.rows = shifted[31:16];
            res.cols = shifted[15:0];
          end
          TYPE_PING[1:0]: begin
            res.kind   = KIND_PING;
            res.cookie = shifted;
          end
          default: begin
            res.kind   = KIND_PONG;
            res.cookie = shifted;
          end
        endcase
      end else begin
        cnt_d = cnt_q + 3'd1;
      end
    end
  end

  // a byte with no result never waits for the output slot
  assign adv_o      = item_i.valid && (!res_valid || out_free_i);
  assign res_o.push = adv_o && res_valid;
  assign res_o.res  = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CNT_IDLE;
      cmd_q <= '0;
    end else if (adv_o) begin
      cnt_q <= cnt_d;
      cmd_q <= cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      pay_q <= pay_d;
    end
  end

endmodule

### src/ecsd_out_reg.sv
module ecsd_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ecsd_pkg::res_item_t res_i,
  output logic                out_free_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ecsd_pkg::result_t   res_o
);
  import ecsd_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign out_free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_i.push) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.push) begin
      res_q <= res_i.res;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

### src/ecsd_checker.sv
module ecsd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  kind_o,
  input logic [7:0]  data_byte_o,
  input logic [31:0] cookie_o,
  input logic [15:0] rows_o,
  input logic [15:0] cols_o
);
  import ecsd_pkg::*;

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // nothing is offered right after reset
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result offered out of reset");

  // data byte is only carried by data items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_DATA |-> data_byte_o == 8'd0)
    else $error("stray data byte");

  // cookie only on ping and pong
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_PING && kind_o != KIND_PONG |-> cookie_o == 32'd0)
    else $error("stray cookie");

  // rows and cols only on window size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_WINSIZE |-> rows_o == 16'd0 && cols_o == 16'd0)
    else $error("stray window size");

endmodule

bind escape_command_stream_decoder_core ecsd_checker u_ecsd_checker (.*);

### verif/escape_decode_checker.sv
module escape_decode_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  in_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] cookie_i,
  input  logic [15:0] rows_i,
  input  logic [15:0] cols_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import ecsd_pkg::*;

  logic [2:0]  seq_pos;
  logic [7:0]  cmd_type;
  logic [31:0] payload;
  result_t     expected_results[$];
  int unsigned errs = 0;

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errs++;
    end
  endtask

  // step the predicted deframer by one byte, queue its result if any
  task automatic decode_next_byte(input logic [7:0] b);
    result_t r;
    logic    has_res;
    r = '0;
    has_res = 1'b0;
    if (seq_pos == CNT_IDLE || seq_pos >= SEQ_LEN) begin
      if (b == ESC_BYTE) begin
        seq_pos = CNT_ESC;
      end else begin
        seq_pos = CNT_IDLE;
        r.kind = KIND_DATA;
        r.data_byte = b;
        has_res = 1'b1;
      end
    end else if (seq_pos == CNT_ESC) begin
      if (b == ESC_BYTE) begin
        seq_pos = CNT_IDLE;
        r.kind = KIND_DATA;
        r.data_byte = ESC_BYTE;
        has_res = 1'b1;
      end else if (b == TYPE_WINSIZE || b == TYPE_PING || b == TYPE_PONG) begin
        cmd_type = b;
        payload = '0;
        seq_pos = CNT_PAY0;
      end else begin
        seq_pos = CNT_IDLE;
        r.kind = KIND_ERROR;
        has_res = 1'b1;
      end
    end else begin
      payload = {payload[23:0], b};
      seq_pos = seq_pos + 3'd1;
      if (seq_pos == SEQ_LEN) begin
        seq_pos = CNT_IDLE;
        has_res = 1'b1;
        case (cmd_type)
          TYPE_WINSIZE: begin
            r.kind = KIND_WINSIZE;
            r.rows = payload[31:16];
            r.cols = payload[15:0];
          end
          TYPE_PING: begin
            r.kind = KIND_PING;
            r.cookie = payload;
          end
          default: begin
            r.kind = KIND_PONG;
            r.cookie = payload;
          end
        endcase
      end
    end
    if (has_res) expected_results = {expected_results, r};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      seq_pos = CNT_IDLE;
      cmd_type = '0;
      payload = '0;
      fail_count_o <= errs;
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) decode_next_byte(in_byte_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0h", $time, kind_i);
          errs++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind_i));
          check_field("data_byte", 32'(want.data_byte), 32'(data_byte_i));
          check_field("cookie", want.cookie, cookie_i);
          check_field("rows", 32'(want.rows), 32'(rows_i));
          check_field("cols", 32'(want.cols), 32'(cols_i));
        end
      end
      fail_count_o <= errs;
      pending_o <= expected_results.size();
    end
  end

endmodule

### verif/testbench.sv
module testbench;
  import ecsd_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_byte = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [2:0]  kind;
  logic [7:0]  data_byte;
  logic [31:0] cookie;
  logic [15:0] rows;
  logic [15:0] cols;
  int unsigned fail_count;
  int unsigned pending;

  // steady: both sides run without gaps or stalls
  logic        steady = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned cmds_sent = 0;
  int unsigned ff_pairs = 0;
  int unsigned noise_seqs = 0;

  always #10 clk = ~clk;

  escape_command_stream_decoder_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_byte_i   (in_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .kind_o      (kind),
    .data_byte_o (data_byte),
    .cookie_o    (cookie),
    .rows_o      (rows),
    .cols_o      (cols)
  );

  escape_decode_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_byte_i    (in_byte),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .kind_i       (kind),
    .data_byte_i  (data_byte),
    .cookie_i     (cookie),
    .rows_i       (rows),
    .cols_i       (cols),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // receiver stalls at random, except in the steady stretch
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 38);
  end

  // offer one byte, with an optional random gap first, and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // escape, type, then four payload bytes, most significant first
  task automatic send_command(input logic [7:0] cmd, input logic [31:0] body);
    send_byte(ESC_BYTE);
    send_byte(cmd);
    for (int i = 3; i >= 0; i--) send_byte(body[i*8 +: 8]);
    cmds_sent++;
  endtask

  // payload byte biased toward the escape value and zero
  function automatic logic [7:0] payload_byte();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return ESC_BYTE;
    if (roll < 25) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int unsigned pick;
    int unsigned guard;
    logic [7:0]  cmd;
    logic [31:0] body;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: plain data extremes
    send_byte(8'h00);
    send_byte(8'hFE);
    // doubled escape gives a literal 0xFF
    send_byte(ESC_BYTE);
    send_byte(ESC_BYTE);
    ff_pairs++;
    // window size with escape bytes inside the payload
    send_command(TYPE_WINSIZE, 32'hFF00_FF00);
    send_command(TYPE_PING, 32'h0000_0000);
    send_command(TYPE_PONG, 32'hFFFF_FFFF);
    // unknown type bytes give the error result
    send_byte(ESC_BYTE);
    send_byte(8'h00);
    send_byte(ESC_BYTE);
    send_byte(8'h04);
    noise_seqs += 2;

    // random: mostly well-formed commands with random content
    while (bytes_sent < 1950) begin
      steady <= (bytes_sent >= 700 && bytes_sent < 1000);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        case ($urandom_range(0, 2))
          0: cmd = TYPE_WINSIZE;
          1: cmd = TYPE_PING;
          default: cmd = TYPE_PONG;
        endcase
        body = {payload_byte(), payload_byte(), payload_byte(), payload_byte()};
        send_command(cmd, body);
      end else if (pick < 60) begin
        send_byte(ESC_BYTE);
        send_byte(ESC_BYTE);
        ff_pairs++;
      end else if (pick < 88) begin
        send_byte(8'($urandom_range(0, 254)));
      end else begin
        // broken or unknown escape: any byte may follow
        send_byte(ESC_BYTE);
        send_byte(8'($urandom_range(0, 255)));
        noise_seqs++;
      end
    end
    steady <= 1'b0;

    // close a sequence left open by noise, then drain
    for (int i = 0; i < 6; i++) send_byte(8'h41);
    in_valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (pending != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);

    $display("covered %0d bytes: %0d commands, %0d escaped 0xFF pairs, %0d noisy escapes",
             bytes_sent, cmds_sent, ff_pairs, noise_seqs);
    if (pending != 0) $display("%0d results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
